@@ rtl/smpg_pkg.sv @@
package smpg_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_STEPS_PER_REV    = 3'd0;
    localparam logic [2:0] REG_MICROSTEP_FACTOR = 3'd1;
    localparam logic [2:0] REG_LEAD_PER_REV     = 3'd2;
    localparam logic [2:0] REG_MIN_PULSE_US     = 3'd3;
    localparam logic [2:0] REG_ACCEL_RATE       = 3'd4;
    localparam logic [2:0] REG_DAMPING_DISTANCE = 3'd5;

    // Fixed constants of the timing arithmetic.
    localparam logic [31:0] US_PER_S = 32'd1000000;
    localparam logic [23:0] HALF_MAX = 24'hFFFFFF;

    // Widths of the shared serial units.
    localparam int unsigned MUL_A_W = 64;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned DIV_W   = 64;

    // Status that each serial unit reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    // Sequencer states: idle, one for each multiply or divide of an update, the speed update and the finish.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_NA,
        S_MUL_NE,
        S_MUL_DM,
        S_DIV_INC,
        S_MUL_LM,
        S_MUL_PM,
        S_DIV_MAX,
        S_UPD_SPD,
        S_MUL_HS,
        S_DIV_HALF,
        S_DIV_STEP,
        S_FINISH
    } t_state;

endpackage

@@ rtl/smpg_mul.sv @@
module smpg_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [smpg_pkg::MUL_A_W-1:0]        i_a,
    input  logic [smpg_pkg::MUL_B_W-1:0]        i_b,
    output logic [smpg_pkg::MUL_A_W-1:0]        o_product,
    output smpg_pkg::t_unit_status              o_status
);

    localparam int unsigned CNT_W = $clog2(smpg_pkg::MUL_B_W);

    logic [smpg_pkg::MUL_A_W-1:0] r_acc;
    logic [smpg_pkg::MUL_A_W-1:0] r_a;
    logic [smpg_pkg::MUL_B_W-1:0] r_b;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;

    // Control: one multiplier bit is consumed per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(smpg_pkg::MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift and add.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[smpg_pkg::MUL_A_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[smpg_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_product     = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

@@ rtl/smpg_div.sv @@
module smpg_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [smpg_pkg::DIV_W-1:0]      i_num,
    input  logic [smpg_pkg::DIV_W-1:0]      i_den,
    output logic [smpg_pkg::DIV_W-1:0]      o_quot,
    output smpg_pkg::t_unit_status          o_status
);

    localparam int unsigned CNT_W = $clog2(smpg_pkg::DIV_W);

    logic [smpg_pkg::DIV_W-1:0] r_num;
    logic [smpg_pkg::DIV_W-1:0] r_rem;
    logic [smpg_pkg::DIV_W-1:0] r_den;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [smpg_pkg::DIV_W:0]   trial;
    logic [smpg_pkg::DIV_W:0]   diff;
    logic                       ge;

    // One quotient bit per cycle, restoring form.
    assign trial = {r_rem, r_num[smpg_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(smpg_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out on top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[smpg_pkg::DIV_W-1:0] : trial[smpg_pkg::DIV_W-1:0];
            r_num <= {r_num[smpg_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_quot        = r_num;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

@@ rtl/stepper_axis_motion_pulse_generator_unit.sv @@
// One item is in flight at a time; the next is accepted only once the previous one is through.
// Each item runs six multiplier passes (32 serial steps plus start and done), four divider
// passes (64 steps plus start and done), one speed update state, one finish state and the
// idle state that accepts the next item.
// A stalled result holds the sequencer in its finish state until the output slot frees.
// Reset (synchronous, active low) restores register defaults, clears position, speed, timer.
module stepper_axis_motion_pulse_generator_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_elapsed_us,
    input  logic signed [31:0] i_target_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_step_level,
    output logic               o_move_forward,
    output logic               o_stepped,
    output logic signed [31:0] o_axis_position,
    output logic [31:0]        o_axis_speed,
    output logic [23:0]        o_half_period_us,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    // Deadband: |d| * 10000 > 2^FRAC_BITS is the same as |d| > floor(2^FRAC_BITS / 10000).
    localparam logic [32:0] DEADBAND = 33'((64'd1 << FRAC_BITS) / 64'd10000);

    localparam int unsigned AW = smpg_pkg::MUL_A_W;
    localparam int unsigned BW = smpg_pkg::MUL_B_W;
    localparam int unsigned DW = smpg_pkg::DIV_W;

    // Configuration registers.
    logic [9:0]  r_steps;
    logic [8:0]  r_micro;
    logic [23:0] r_lead;
    logic [15:0] r_minp;
    logic [23:0] r_accel;
    logic [23:0] r_damp;

    // Axis state.
    logic signed [31:0] r_pos;
    logic [31:0]        r_speed;
    logic [31:0]        r_timer;
    logic               r_pin;
    logic               r_dir;

    // Per-item working registers.
    logic [15:0] r_elapsed;
    logic [23:0] r_near;
    logic [18:0] r_mpr;
    logic [23:0] r_damp_nz;
    logic        r_db;
    logic [AW-1:0] r_prod;
    logic [AW-1:0] r_num_inc;
    logic [AW-1:0] r_den_inc;
    logic [AW-1:0] r_lmill;
    logic [DW-1:0] r_inc;
    logic [DW-1:0] r_maxspd;
    logic [23:0]   r_half;
    logic [23:0]   r_step;

    // Output slot.
    logic               r_out_valid;
    logic               r_out_pin;
    logic               r_out_dir;
    logic               r_out_stepped;
    logic signed [31:0] r_out_pos;
    logic [31:0]        r_out_speed;
    logic [23:0]        r_out_half;

    // Sequencer.
    smpg_pkg::t_state r_state;
    smpg_pkg::t_state n_state;
    logic             r_go;

    // Serial unit connections.
    logic                   mul_start;
    logic [AW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic [AW-1:0]          mul_p;
    smpg_pkg::t_unit_status mul_st;
    logic                   div_start;
    logic [DW-1:0]          div_n;
    logic [DW-1:0]          div_d;
    logic [DW-1:0]          div_q;
    smpg_pkg::t_unit_status div_st;

    logic in_acc;
    logic out_acc;
    logic slot_free;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = r_out_valid && !i_out_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    smpg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_product (mul_p),
        .o_status  (mul_st)
    );

    smpg_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_n),
        .i_den    (div_d),
        .o_quot   (div_q),
        .o_status (div_st)
    );

    // Values derived at acceptance of an item.
    logic [9:0]         steps_nz;
    logic [8:0]         micro_nz;
    logic [23:0]        damp_nz;
    logic [15:0]        minp_nz;
    logic signed [32:0] delta;
    logic [32:0]        absd;
    logic [32:0]        timer_sum;

    assign steps_nz  = (r_steps == '0) ? 10'd1 : r_steps;
    assign micro_nz  = (r_micro == '0) ? 9'd1 : r_micro;
    assign damp_nz   = (r_damp == '0) ? 24'd1 : r_damp;
    assign minp_nz   = (r_minp == '0) ? 16'd1 : r_minp;
    assign delta     = 33'(i_target_position) - 33'(r_pos);
    assign absd      = delta[32] ? 33'(-delta) : 33'(delta);
    assign timer_sum = {1'b0, r_timer} + {17'd0, i_elapsed_us};

    // Speed update: capped increment, saturating sum.
    logic [DW-1:0] inc_cap;
    logic [DW:0]   spd_sum;
    logic [31:0]   spd_new;

    assign inc_cap = (r_inc > r_maxspd) ? r_maxspd : r_inc;
    assign spd_sum = {1'b0, inc_cap} + {33'd0, r_speed};
    assign spd_new = (spd_sum > {33'd0, 32'hFFFFFFFF}) ? 32'hFFFFFFFF : spd_sum[31:0];

    // Toggle and step decision for the final cycle.
    logic [23:0]        floor_half;
    logic               toggle;
    logic               pin_next;
    logic               fall;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat;

    assign floor_half = (r_half < {8'd0, r_minp}) ? {8'd0, r_minp} : r_half;
    assign toggle     = r_db && (r_timer > {8'd0, floor_half});
    assign pin_next   = toggle ? !r_pin : r_pin;
    assign fall       = toggle && r_pin;
    assign pos_sum    = r_dir ? (33'(r_pos) + $signed({9'd0, r_step}))
                              : (33'(r_pos) - $signed({9'd0, r_step}));
    assign pos_sat    = (pos_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (pos_sum < -33'sh0_8000_0000) ? -32'sh8000_0000 : pos_sum[31:0];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            smpg_pkg::S_IDLE:     if (in_acc) n_state = smpg_pkg::S_MUL_NA;
            smpg_pkg::S_MUL_NA:   if (mul_st.done) n_state = smpg_pkg::S_MUL_NE;
            smpg_pkg::S_MUL_NE:   if (mul_st.done) n_state = smpg_pkg::S_MUL_DM;
            smpg_pkg::S_MUL_DM:   if (mul_st.done) n_state = smpg_pkg::S_DIV_INC;
            smpg_pkg::S_DIV_INC:  if (div_st.done) n_state = smpg_pkg::S_MUL_LM;
            smpg_pkg::S_MUL_LM:   if (mul_st.done) n_state = smpg_pkg::S_MUL_PM;
            smpg_pkg::S_MUL_PM:   if (mul_st.done) n_state = smpg_pkg::S_DIV_MAX;
            smpg_pkg::S_DIV_MAX:  if (div_st.done) n_state = smpg_pkg::S_UPD_SPD;
            smpg_pkg::S_UPD_SPD:  n_state = smpg_pkg::S_MUL_HS;
            smpg_pkg::S_MUL_HS:   if (mul_st.done) n_state = smpg_pkg::S_DIV_HALF;
            smpg_pkg::S_DIV_HALF: if (div_st.done) n_state = smpg_pkg::S_DIV_STEP;
            smpg_pkg::S_DIV_STEP: if (div_st.done) n_state = smpg_pkg::S_FINISH;
            smpg_pkg::S_FINISH:   if (slot_free) n_state = smpg_pkg::S_IDLE;
            default:              n_state = smpg_pkg::S_IDLE;
        endcase
    end

    // Operand selection and unit start pulses.
    always_comb begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_n     = '0;
        div_d     = '0;
        case (r_state)
            smpg_pkg::S_MUL_NA: begin
                mul_start = r_go;
                mul_a     = AW'(r_near);
                mul_b     = BW'(r_accel);
            end
            smpg_pkg::S_MUL_NE: begin
                mul_start = r_go;
                mul_a     = r_prod;
                mul_b     = BW'(r_elapsed);
            end
            smpg_pkg::S_MUL_DM: begin
                mul_start = r_go;
                mul_a     = AW'(r_damp_nz);
                mul_b     = smpg_pkg::US_PER_S;
            end
            smpg_pkg::S_DIV_INC: begin
                div_start = r_go;
                div_n     = r_num_inc;
                div_d     = r_den_inc;
            end
            smpg_pkg::S_MUL_LM: begin
                mul_start = r_go;
                mul_a     = AW'(r_lead);
                mul_b     = smpg_pkg::US_PER_S;
            end
            smpg_pkg::S_MUL_PM: begin
                mul_start = r_go;
                mul_a     = AW'({r_mpr, 1'b0});
                mul_b     = BW'(minp_nz);
            end
            smpg_pkg::S_DIV_MAX: begin
                div_start = r_go;
                div_n     = r_lmill;
                div_d     = r_prod;
            end
            smpg_pkg::S_MUL_HS: begin
                mul_start = r_go;
                mul_a     = AW'({r_mpr, 1'b0});
                mul_b     = r_speed;
            end
            smpg_pkg::S_DIV_HALF: begin
                div_start = r_go;
                div_n     = r_lmill;
                div_d     = r_prod;
            end
            smpg_pkg::S_DIV_STEP: begin
                div_start = r_go;
                div_n     = DW'(r_lead);
                div_d     = DW'(r_mpr);
            end
            default: begin
                mul_start = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // Sequencer state and start flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smpg_pkg::S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= 10'd200;
            r_micro <= 9'd1;
            r_lead  <= 24'd83231;
            r_minp  <= 16'd150;
            r_accel <= 24'd65536;
            r_damp  <= 24'd327680;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                smpg_pkg::REG_STEPS_PER_REV:    r_steps <= i_cfg_data[9:0];
                smpg_pkg::REG_MICROSTEP_FACTOR: r_micro <= i_cfg_data[8:0];
                smpg_pkg::REG_LEAD_PER_REV:     r_lead  <= i_cfg_data;
                smpg_pkg::REG_MIN_PULSE_US:     r_minp  <= i_cfg_data[15:0];
                smpg_pkg::REG_ACCEL_RATE:       r_accel <= i_cfg_data;
                smpg_pkg::REG_DAMPING_DISTANCE: r_damp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Working registers: captured at acceptance and as each unit finishes.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elapsed <= i_elapsed_us;
            r_near    <= (absd < {9'd0, damp_nz}) ? absd[23:0] : damp_nz;
            r_mpr     <= {9'd0, steps_nz} * {10'd0, micro_nz};
            r_damp_nz <= damp_nz;
            r_db      <= (absd > DEADBAND);
        end
        case (r_state)
            smpg_pkg::S_MUL_NA:   if (mul_st.done) r_prod <= mul_p;
            smpg_pkg::S_MUL_NE:   if (mul_st.done) r_num_inc <= mul_p;
            smpg_pkg::S_MUL_DM:   if (mul_st.done) r_den_inc <= mul_p;
            smpg_pkg::S_DIV_INC:  if (div_st.done) r_inc <= div_q;
            smpg_pkg::S_MUL_LM:   if (mul_st.done) r_lmill <= mul_p;
            smpg_pkg::S_MUL_PM:   if (mul_st.done) r_prod <= mul_p;
            smpg_pkg::S_DIV_MAX:  if (div_st.done) r_maxspd <= div_q;
            smpg_pkg::S_MUL_HS:   if (mul_st.done) r_prod <= mul_p;
            smpg_pkg::S_DIV_HALF: begin
                if (div_st.done) begin
                    if (r_speed == '0 || div_q > DW'(smpg_pkg::HALF_MAX)) begin
                        r_half <= smpg_pkg::HALF_MAX;
                    end else begin
                        r_half <= div_q[23:0];
                    end
                end
            end
            smpg_pkg::S_DIV_STEP: if (div_st.done) r_step <= div_q[23:0];
            default: ;
        endcase
    end

    // Axis state: timer and direction on acceptance, speed mid-item, pin, position and a timer clear at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_speed <= '0;
            r_timer <= '0;
            r_pin   <= 1'b0;
            r_dir   <= 1'b1;
        end else begin
            if (in_acc) begin
                r_timer <= timer_sum[32] ? 32'hFFFFFFFF : timer_sum[31:0];
                r_dir   <= (i_target_position > r_pos);
            end
            if (r_state == smpg_pkg::S_UPD_SPD) begin
                r_speed <= spd_new;
            end
            if (r_state == smpg_pkg::S_FINISH && slot_free) begin
                r_pin <= pin_next;
                if (toggle) begin
                    r_timer <= '0;
                end
                if (fall) begin
                    r_pos <= pos_sat;
                end
            end
        end
    end

    // Output slot: valid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == smpg_pkg::S_FINISH && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output slot: payload.
    always_ff @(posedge i_clk) begin
        if (r_state == smpg_pkg::S_FINISH && slot_free) begin
            r_out_pin     <= pin_next;
            r_out_dir     <= r_dir;
            r_out_stepped <= fall;
            r_out_pos     <= fall ? pos_sat : r_pos;
            r_out_speed   <= r_speed;
            r_out_half    <= r_half;
        end
    end

    assign o_in_stall       = (r_state != smpg_pkg::S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_step_level     = r_out_pin;
    assign o_move_forward   = r_out_dir;
    assign o_stepped        = r_out_stepped;
    assign o_axis_position  = r_out_pos;
    assign o_axis_speed     = r_out_speed;
    assign o_half_period_us = r_out_half;

    // The two serial units are never run at the same time.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_st.busy && div_st.busy))
        else $error("multiplier and divider busy together");

    // An accepted item always starts the sequence.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == smpg_pkg::S_MUL_NA))
        else $error("accepted item did not start the sequence");

    // A position step only happens on a falling edge of the step pin.
    a_step_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stepped) |-> !r_out_pin)
        else $error("step reported without a falling edge");

    // A unit finishes only while the sequencer is out of the idle state.
    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_st.done || div_st.done) |-> (r_state != smpg_pkg::S_IDLE))
        else $error("unit finished while the sequencer was idle");

endmodule
